FILE: design/dltq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dltq_pkg;
   localparam int NUM_TIMERS_DEF = 16;
   localparam int TIME_W = 31;
   localparam int ID_W = 4;
   localparam int CMD_W = 2;
   localparam int KIND_W = 2;
   localparam logic RELOAD_ENABLE = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD = 2'd0, CMD_REMOVE = 2'd1, CMD_TICK = 2'd2, CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DONE = 2'd0, KIND_EXPIRED = 2'd1, KIND_REJECT = 2'd2, KIND_SPARE = 2'd3
   } kind_type;

   typedef struct packed {
      cmd_type           command;
      logic [ID_W-1:0]   timer_id;
      logic [TIME_W-1:0] delay_ms;
      logic              periodic;
      logic [TIME_W-1:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      kind_type        kind;
      logic [ID_W-1:0] timer_id_res;
      logic            last;
   } rsp_type;
endpackage
`default_nettype wire

FILE: design/dltq_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dltq_req_if import dltq_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dltq_rsp_if import dltq_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: design/delta_list_timer_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake           | payload
// req     | in  | req_valid/req_ready | command, timer_id, delay_ms, periodic, elapsed_ms
// rsp     | out | rsp_valid/rsp_ready | kind, timer_id_res, last
// Remove walks to the entry and closes the gap; add removes it first when the id is
// active, then walks and inserts. Tick pops each expired timer from the front, emits
// the expiries in order, and does an insert walk for each periodic reload.
// Synchronous active-high reset empties the list.
// While a result waits the engine pops no request or expiry; the two-entry queue fills.
module delta_list_timer_queue_top import dltq_pkg::*; #(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   dltq_req_if.sink req,
   dltq_rsp_if.source rsp
);
   req_type q_data;
   logic    q_valid, q_pop;

   dltq_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
   );

   dltq_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
      .clock(clock), .reset(reset), .q_data(q_data), .q_valid(q_valid),
      .q_pop(q_pop), .rsp(rsp)
   );
endmodule
`default_nettype wire

FILE: design/dltq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-entry request queue between the port and the list engine.
module dltq_front import dltq_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   dltq_req_if.sink  req,
   output req_type   q_data,
   output logic      q_valid,
   input  wire logic q_pop
);
   req_type   mem_ff [2];
   logic      wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign req.ready = (cnt_ff != 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) mem_ff[wp_ff] <= req.payload;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (req.valid && req.ready) wp_ff <= ~wp_ff;
         if (q_pop && q_valid) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(req.valid && req.ready) - 2'(q_pop && q_valid);
      end
   end
endmodule
`default_nettype wire

FILE: design/dltq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// List engine: walks the delta list one entry per cycle.
module dltq_back import dltq_pkg::*; #(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  var req_type q_data,
   input  wire logic q_valid,
   output logic      q_pop,
   dltq_rsp_if.source rsp
);
   localparam int PW = $clog2(NUM_TIMERS);
   localparam int CW = $clog2(NUM_TIMERS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DQ_FIND, S_DQ_SHIFT, S_ENQ_SCAN, S_ENQ_SHIFT,
      S_TICK, S_TICK_POP, S_EMIT, S_RELOAD, S_OUT
   } state_type;

   state_type        state_ff;
   logic [PW-1:0]    order_ff [NUM_TIMERS];
   logic [TIME_W-1:0] delta_ff [NUM_TIMERS];
   logic [TIME_W-1:0] reload_ff [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] per_ff, act_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    i_ff;      // walk index
   logic [CW-1:0]    k_ff;      // shift index
   logic [PW-1:0]    id_ff;
   logic [TIME_W-1:0] rem_ff;
   logic [CW-1:0]    pos_ff;
   logic             is_add_ff;
   logic [PW-1:0]    due_ff [NUM_TIMERS];
   logic [CW-1:0]    ndue_ff, di_ff;
   logic             in_tick_ff;
   rsp_type          out_ff;
   logic             ov_ff;

   logic [PW-1:0]    cur;
   logic [TIME_W-1:0] dcur;
   logic [ID_W-1:0]  rid;
   logic             id_ok;
   logic             reject;
   logic             ov_set;

   assign cur = order_ff[i_ff[PW-1:0]];
   assign dcur = delta_ff[cur];
   assign rid = q_data.timer_id;
   assign id_ok = ({{(32-ID_W){1'b0}}, rid} < 32'(NUM_TIMERS));
   assign reject = (q_data.command == CMD_ADD || q_data.command == CMD_REMOVE) &&
                   (!id_ok || (q_data.command == CMD_REMOVE && !act_ff[rid[PW-1:0]]));
   // a new result is loaded at this edge
   assign ov_set = (state_ff == S_IDLE && q_valid && !ov_ff && reject) ||
                   (state_ff == S_EMIT && di_ff < ndue_ff && (!ov_ff || rsp.ready)) ||
                   (state_ff == S_OUT);
   assign q_pop = (state_ff == S_IDLE) && q_valid && !ov_ff;
   assign rsp.valid = ov_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         per_ff <= '0;
         act_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         if (ov_set) ov_ff <= 1'b1;
         else if (rsp.ready) ov_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid && !ov_ff) begin
                  id_ff <= rid[PW-1:0];
                  rem_ff <= (q_data.command == CMD_TICK) ? q_data.elapsed_ms :
                                                           q_data.delay_ms;
                  is_add_ff <= (q_data.command == CMD_ADD);
                  in_tick_ff <= 1'b0;
                  i_ff <= '0;
                  priority if (q_data.command == CMD_TICK) begin
                     ndue_ff <= '0;
                     state_ff <= S_TICK;
                  end else if (q_data.command == CMD_NONE) begin
                     state_ff <= S_IDLE;
                  end else if (reject) begin
                     out_ff <= '{KIND_REJECT, rid, 1'b1};
                  end else begin
                     if (q_data.command == CMD_ADD) begin
                        reload_ff[rid[PW-1:0]] <= q_data.delay_ms;
                        per_ff[rid[PW-1:0]] <= q_data.periodic & RELOAD_ENABLE;
                     end
                     state_ff <= act_ff[rid[PW-1:0]] ? S_DQ_FIND :
                                 (q_data.command == CMD_ADD) ? S_ENQ_SCAN : S_OUT;
                  end
               end
            end
            S_DQ_FIND: begin
               if (cur == id_ff) begin
                  if (i_ff + 1'b1 < count_ff)
                     delta_ff[order_ff[i_ff[PW-1:0] + 1'b1]] <=
                        delta_ff[order_ff[i_ff[PW-1:0] + 1'b1]] + delta_ff[id_ff];
                  k_ff <= i_ff;
                  state_ff <= S_DQ_SHIFT;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            S_DQ_SHIFT: begin
               if (k_ff + 1'b1 < count_ff) begin
                  order_ff[k_ff[PW-1:0]] <= order_ff[k_ff[PW-1:0] + 1'b1];
                  k_ff <= k_ff + 1'b1;
               end else begin
                  count_ff <= count_ff - 1'b1;
                  act_ff[id_ff] <= 1'b0;
                  i_ff <= '0;
                  state_ff <= is_add_ff ? S_ENQ_SCAN : S_OUT;
               end
            end
            S_ENQ_SCAN: begin
               k_ff <= count_ff;
               if (i_ff >= count_ff) begin
                  delta_ff[id_ff] <= rem_ff;
                  pos_ff <= count_ff;
                  state_ff <= S_ENQ_SHIFT;
               end else if (rem_ff > dcur) begin
                  rem_ff <= rem_ff - dcur;
                  i_ff <= i_ff + 1'b1;
               end else if (rem_ff == dcur) begin
                  delta_ff[id_ff] <= '0;
                  pos_ff <= i_ff + 1'b1;
                  state_ff <= S_ENQ_SHIFT;
               end else begin
                  delta_ff[cur] <= dcur - rem_ff;
                  delta_ff[id_ff] <= rem_ff;
                  pos_ff <= i_ff;
                  state_ff <= S_ENQ_SHIFT;
               end
            end
            S_ENQ_SHIFT: begin
               if (k_ff > pos_ff) begin
                  order_ff[k_ff[PW-1:0]] <= order_ff[k_ff[PW-1:0] - 1'b1];
                  k_ff <= k_ff - 1'b1;
               end else begin
                  order_ff[pos_ff[PW-1:0]] <= id_ff;
                  count_ff <= count_ff + 1'b1;
                  act_ff[id_ff] <= 1'b1;
                  state_ff <= in_tick_ff ? S_EMIT : S_OUT;
               end
            end
            S_TICK: begin
               i_ff <= '0;
               if (count_ff == '0) begin
                  di_ff <= '0;
                  state_ff <= S_EMIT;
               end else if (dcur > rem_ff) begin
                  delta_ff[cur] <= dcur - rem_ff;
                  di_ff <= '0;
                  state_ff <= S_EMIT;
               end else begin
                  rem_ff <= rem_ff - dcur;
                  delta_ff[cur] <= '0;
                  act_ff[cur] <= 1'b0;
                  due_ff[ndue_ff[PW-1:0]] <= cur;
                  ndue_ff <= ndue_ff + 1'b1;
                  k_ff <= '0;
                  state_ff <= S_TICK_POP;
               end
            end
            S_TICK_POP: begin
               if (k_ff + 1'b1 < count_ff) begin
                  order_ff[k_ff[PW-1:0]] <= order_ff[k_ff[PW-1:0] + 1'b1];
                  k_ff <= k_ff + 1'b1;
               end else begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_TICK;
               end
            end
            S_EMIT: begin
               // one expiry out, then optional reinsert
               if (di_ff >= ndue_ff) begin
                  state_ff <= S_IDLE;
               end else if (!ov_ff || rsp.ready) begin
                  out_ff <= '{KIND_EXPIRED, ID_W'(due_ff[di_ff[PW-1:0]]),
                              (di_ff + 1'b1 == ndue_ff)};
                  di_ff <= di_ff + 1'b1;
                  id_ff <= due_ff[di_ff[PW-1:0]];
                  rem_ff <= reload_ff[due_ff[di_ff[PW-1:0]]];
                  state_ff <= per_ff[due_ff[di_ff[PW-1:0]]] ? S_RELOAD : S_EMIT;
               end
            end
            S_RELOAD: begin
               in_tick_ff <= 1'b1;
               i_ff <= '0;
               state_ff <= S_ENQ_SCAN;
            end
            S_OUT: begin
               out_ff <= '{KIND_DONE, ID_W'(id_ff), 1'b1};
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
